// ----- rtl/core/mrte_pkg.sv -----
`timescale 1ns / 1ps
package mrte_pkg;

    typedef enum logic [4:0] {
        OP_AND = 5'd0, OP_ADDU = 5'd1, OP_ADD = 5'd2, OP_SUBU = 5'd3, OP_SUB = 5'd4,
        OP_NOR = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SLL = 5'd8, OP_SRL = 5'd9,
        OP_SLLV = 5'd10, OP_SRLV = 5'd11, OP_SRA = 5'd12, OP_SRAV = 5'd13,
        OP_SLT = 5'd14, OP_SLTU = 5'd15, OP_MFHI = 5'd16, OP_MTHI = 5'd17,
        OP_MFLO = 5'd18, OP_MTLO = 5'd19, OP_MULT = 5'd20, OP_MULTU = 5'd21,
        OP_DIV = 5'd22, OP_DIVU = 5'd23, OP_JR = 5'd24, OP_JALR = 5'd25,
        OP_SYSCALL = 5'd26, OP_BREAK = 5'd27
    } op_t;

    typedef enum logic [1:0] {
        EXC_NONE = 2'd0, EXC_OVERFLOW = 2'd1, EXC_SYSCALL = 2'd2, EXC_BREAK = 2'd3
    } exc_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic [4:0]  operation;
        logic [31:0] instruction_word;
        logic [31:0] current_pc;
        logic        in_delay_slot;
    } req_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_register;
        logic [31:0] write_value;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic [1:0]  exception_code;
        logic [31:0] exception_pc;
        logic        exception_in_delay_slot;
    } rsp_t;

    localparam logic [31:0] LINK_OFFSET = 32'd8;
    localparam logic [31:0] SLOT_OFFSET = 32'd4;

endpackage

// ----- rtl/core/mrte_if.sv -----
`timescale 1ns / 1ps
interface mrte_req_if;
    logic           valid;
    logic           ready;
    mrte_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mrte_rsp_if;
    logic           valid;
    logic           ready;
    mrte_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mips_r_type_execute.sv -----
`timescale 1ns / 1ps
// A request passes through the queue, the register file read and execute, and then its
// result is registered; div and divu with a nonzero divisor also wait on the divider.
// The back end works one request at a time and takes no new one until it is done. Reset
// clears hi, lo, the queue and per-register valid bits, so every register reads as zero
// until written.
module mips_r_type_execute (
    input logic clk,
    input logic rst_n,
    mrte_req_if.sink   req,
    mrte_rsp_if.source rsp
);
    // The front queue holds requests so the upstream side can keep issuing
    // while the back end executes or waits on the divider.
    mrte_req_if q_ch ();

    mrte_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(req), .out_ch(q_ch));
    mrte_back  u_back  (.clk(clk), .rst_n(rst_n), .in_ch(q_ch), .out_ch(rsp));

    // A result never reports a write to register zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.payload.write_enable && rsp.payload.write_register == 5'd0))
        else $error("write to register zero reported");

    // A result with an exception never carries a register write.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.exception_code != mrte_pkg::EXC_NONE
        |-> !rsp.payload.write_enable)
        else $error("write alongside an exception");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("stalled result changed");
endmodule

// ----- rtl/core/mrte_ram.sv -----
`timescale 1ns / 1ps
module mrte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end
endmodule

// ----- rtl/core/mrte_front.sv -----
`timescale 1ns / 1ps
// Two-entry queue that accepts requests and decouples them from the execute side.
module mrte_front (
    input  logic clk,
    input  logic rst_n,
    mrte_req_if.sink   in_ch,
    mrte_req_if.source out_ch
);
    mrte_pkg::req_t entry_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     count_reg;
    logic           push, pop;

    assign in_ch.ready    = (count_reg != 2'd2);
    assign out_ch.valid   = (count_reg != 2'd0);
    assign out_ch.payload = entry_reg[rptr_reg];
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= in_ch.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/core/mrte_divider.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module mrte_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] quo_reg, rem_reg, dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted   = {rem_reg, quo_reg[31]};
    assign trial     = shifted - {1'b0, dsr_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = busy_reg && (cnt_reg == 6'd0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 32'd0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 6'd1;
        end
    end
endmodule

// ----- rtl/core/mrte_back.sv -----
`timescale 1ns / 1ps
// Execute side: register file read, ALU, multiply, divide, and the result register.
module mrte_back (
    input  logic clk,
    input  logic rst_n,
    mrte_req_if.sink   in_ch,
    mrte_rsp_if.source out_ch
);
    mrte_pkg::state_t state_reg, state_next;
    mrte_pkg::req_t   cur_reg;
    mrte_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [31:0]      hi_reg, hi_next, lo_reg, lo_next;
    logic [31:0]      valid_reg, valid_next;
    logic             rs_nz_reg, rt_nz_reg;
    logic [31:0]      rf_a, rf_b, rs, rt;
    logic [4:0]       rs_idx, rt_idx, rd, sa, vsa;
    logic             rf_we;
    logic [31:0]      sum, dif;
    logic [63:0]      prod_s, prod_u;
    logic             div_start, div_done;
    logic             neg_a, neg_b, div_signed;
    logic [31:0]      div_q, div_r;
    logic             wr;
    logic [31:0]      val;
    logic             accept;

    // While idle the read addresses follow the offered request; once it is taken they
    // follow the held request, so the read data stays valid through execute and divide.
    assign rs_idx = (state_reg == mrte_pkg::ST_IDLE) ?
                    in_ch.payload.instruction_word[25:21] : cur_reg.instruction_word[25:21];
    assign rt_idx = (state_reg == mrte_pkg::ST_IDLE) ?
                    in_ch.payload.instruction_word[20:16] : cur_reg.instruction_word[20:16];
    assign rd     = cur_reg.instruction_word[15:11];
    assign sa     = cur_reg.instruction_word[10:6];

    mrte_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .clk(clk), .we(rf_we), .waddr(rd), .wdata(val),
        .raddr_a(rs_idx), .rdata_a(rf_a), .raddr_b(rt_idx), .rdata_b(rf_b)
    );

    assign rs  = rs_nz_reg ? rf_a : 32'd0;
    assign rt  = rt_nz_reg ? rf_b : 32'd0;
    assign vsa = rs[4:0];
    assign sum = rs + rt;
    assign dif = rs - rt;
    assign prod_s = $signed(rs) * $signed(rt);
    assign prod_u = rs * rt;
    assign div_signed = (cur_reg.operation == mrte_pkg::OP_DIV);
    assign neg_a = div_signed && rs[31];
    assign neg_b = div_signed && rt[31];

    mrte_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(neg_a ? 32'd0 - rs : rs), .divisor(neg_b ? 32'd0 - rt : rt),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    assign in_ch.ready    = (state_reg == mrte_pkg::ST_IDLE) && (!rsp_valid_reg || out_ch.ready);
    assign accept         = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = rsp_valid_reg;
    assign out_ch.payload = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        valid_next     = valid_reg;
        wr             = 1'b0;
        val            = 32'd0;
        rf_we          = 1'b0;
        div_start      = 1'b0;
        if (out_ch.valid && out_ch.ready) rsp_valid_next = 1'b0;
        case (state_reg)
            mrte_pkg::ST_IDLE:
            begin
                if (accept) state_next = mrte_pkg::ST_READ;
            end
            mrte_pkg::ST_READ:
            begin
                state_next = mrte_pkg::ST_EXEC;
            end
            mrte_pkg::ST_EXEC:
            begin
                rsp_next = '0;
                case (cur_reg.operation)
                    mrte_pkg::OP_AND:  begin wr = 1'b1; val = rs & rt; end
                    mrte_pkg::OP_ADDU: begin wr = 1'b1; val = sum; end
                    mrte_pkg::OP_ADD:
                    begin
                        if (((rs ^ sum) & (rt ^ sum)) >> 31 != 32'd0)
                            rsp_next.exception_code = mrte_pkg::EXC_OVERFLOW;
                        else begin wr = 1'b1; val = sum; end
                    end
                    mrte_pkg::OP_SUBU: begin wr = 1'b1; val = dif; end
                    mrte_pkg::OP_SUB:
                    begin
                        if (((rs ^ rt) & (rs ^ dif)) >> 31 != 32'd0)
                            rsp_next.exception_code = mrte_pkg::EXC_OVERFLOW;
                        else begin wr = 1'b1; val = dif; end
                    end
                    mrte_pkg::OP_NOR:  begin wr = 1'b1; val = ~(rs | rt); end
                    mrte_pkg::OP_OR:   begin wr = 1'b1; val = rs | rt; end
                    mrte_pkg::OP_XOR:  begin wr = 1'b1; val = rs ^ rt; end
                    mrte_pkg::OP_SLL:  begin wr = 1'b1; val = rt << sa; end
                    mrte_pkg::OP_SRL:  begin wr = 1'b1; val = rt >> sa; end
                    mrte_pkg::OP_SLLV: begin wr = 1'b1; val = rt << vsa; end
                    mrte_pkg::OP_SRLV: begin wr = 1'b1; val = rt >> vsa; end
                    mrte_pkg::OP_SRA:  begin wr = 1'b1; val = $unsigned($signed(rt) >>> sa); end
                    mrte_pkg::OP_SRAV: begin wr = 1'b1; val = $unsigned($signed(rt) >>> vsa); end
                    mrte_pkg::OP_SLT:  begin wr = 1'b1; val = {31'd0, $signed(rs) < $signed(rt)}; end
                    mrte_pkg::OP_SLTU: begin wr = 1'b1; val = {31'd0, rs < rt}; end
                    mrte_pkg::OP_MFHI: begin wr = 1'b1; val = hi_reg; end
                    mrte_pkg::OP_MTHI: hi_next = rs;
                    mrte_pkg::OP_MFLO: begin wr = 1'b1; val = lo_reg; end
                    mrte_pkg::OP_MTLO: lo_next = rs;
                    mrte_pkg::OP_MULT: begin hi_next = prod_s[63:32]; lo_next = prod_s[31:0]; end
                    mrte_pkg::OP_MULTU: begin hi_next = prod_u[63:32]; lo_next = prod_u[31:0]; end
                    mrte_pkg::OP_DIV, mrte_pkg::OP_DIVU:
                    begin
                        if (rt != 32'd0) div_start = 1'b1;
                    end
                    mrte_pkg::OP_JR:
                    begin
                        rsp_next.jump_taken = 1'b1; rsp_next.jump_target = rs;
                    end
                    mrte_pkg::OP_JALR:
                    begin
                        rsp_next.jump_taken = 1'b1; rsp_next.jump_target = rs;
                        wr = 1'b1; val = cur_reg.current_pc + mrte_pkg::LINK_OFFSET;
                    end
                    mrte_pkg::OP_SYSCALL: rsp_next.exception_code = mrte_pkg::EXC_SYSCALL;
                    mrte_pkg::OP_BREAK:   rsp_next.exception_code = mrte_pkg::EXC_BREAK;
                    default: ;
                endcase
                if (rd == 5'd0) wr = 1'b0;
                if (wr)
                begin
                    rf_we = 1'b1;
                    valid_next[rd] = 1'b1;
                    rsp_next.write_enable   = 1'b1;
                    rsp_next.write_register = rd;
                    rsp_next.write_value    = val;
                end
                if (rsp_next.exception_code != mrte_pkg::EXC_NONE)
                begin
                    rsp_next.exception_pc = cur_reg.in_delay_slot ?
                        cur_reg.current_pc - mrte_pkg::SLOT_OFFSET : cur_reg.current_pc;
                    rsp_next.exception_in_delay_slot = cur_reg.in_delay_slot;
                end
                if (div_start) state_next = mrte_pkg::ST_DIVIDE;
                else
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = mrte_pkg::ST_IDLE;
                end
            end
            mrte_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    lo_next = neg_a ^ neg_b ? 32'd0 - div_q : div_q;
                    hi_next = neg_a ? 32'd0 - div_r : div_r;
                    rsp_valid_next = 1'b1;
                    state_next     = mrte_pkg::ST_IDLE;
                end
            end
            default: state_next = mrte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept) cur_reg <= in_ch.payload;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrte_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            valid_reg     <= 32'd0;
            rs_nz_reg     <= 1'b0;
            rt_nz_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            valid_reg     <= valid_next;
            if (accept)
            begin
                rs_nz_reg <= (rs_idx != 5'd0) && valid_reg[rs_idx];
                rt_nz_reg <= (rt_idx != 5'd0) && valid_reg[rt_idx];
            end
        end
    end
endmodule

// ----- tb/mips_r_type_execute_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the MIPS32 R-type execute stage. It drives instruction requests with
// random idling on both sides, mirrors the register file and hi/lo in its own
// predictor, and checks every result field by field against the oldest expectation.
module mips_r_type_execute_tb;

    // Holds the expected results in issue order and counts mismatches.
    class exec_scoreboard;
        mrte_pkg::rsp_t pending_results[$];
        int             error_count;

        function new();
            error_count = 0;
        endfunction

        function void note_request(mrte_pkg::rsp_t predicted);
            pending_results.push_back(predicted);
        endfunction

        function void check_result(mrte_pkg::rsp_t actual);
            mrte_pkg::rsp_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no request pending");
                error_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (actual.write_enable !== exp_r.write_enable)
            begin
                $error("write_enable expected %0h actual %0h",
                       exp_r.write_enable, actual.write_enable);
                error_count++;
            end
            if (actual.write_register !== exp_r.write_register)
            begin
                $error("write_register expected %0h actual %0h",
                       exp_r.write_register, actual.write_register);
                error_count++;
            end
            if (actual.write_value !== exp_r.write_value)
            begin
                $error("write_value expected %0h actual %0h",
                       exp_r.write_value, actual.write_value);
                error_count++;
            end
            if (actual.jump_taken !== exp_r.jump_taken)
            begin
                $error("jump_taken expected %0h actual %0h",
                       exp_r.jump_taken, actual.jump_taken);
                error_count++;
            end
            if (actual.jump_target !== exp_r.jump_target)
            begin
                $error("jump_target expected %0h actual %0h",
                       exp_r.jump_target, actual.jump_target);
                error_count++;
            end
            if (actual.exception_code !== exp_r.exception_code)
            begin
                $error("exception_code expected %0h actual %0h",
                       exp_r.exception_code, actual.exception_code);
                error_count++;
            end
            if (actual.exception_pc !== exp_r.exception_pc)
            begin
                $error("exception_pc expected %0h actual %0h",
                       exp_r.exception_pc, actual.exception_pc);
                error_count++;
            end
            if (actual.exception_in_delay_slot !== exp_r.exception_in_delay_slot)
            begin
                $error("exception_in_delay_slot expected %0h actual %0h",
                       exp_r.exception_in_delay_slot, actual.exception_in_delay_slot);
                error_count++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 800;

    logic clk;
    logic rst_n;

    mrte_req_if req_ch ();
    mrte_rsp_if rsp_ch ();

    mips_r_type_execute u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    exec_scoreboard scoreboard;

    // The predictor's private copy of the architectural state.
    logic [31:0] gpr_mirror [32];
    logic [31:0] hi_mirror;
    logic [31:0] lo_mirror;

    // Idle rates in percent for each side; changed by the stimulus phases.
    int  send_idle_pct;
    int  recv_idle_pct;
    // While set, the receiver refuses every result so the block backs up.
    bit  recv_hold;
    int  cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Global watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] arith_shift_right(logic [31:0] v, logic [4:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    // Computes the result of one instruction and updates the mirrored state.
    function automatic mrte_pkg::rsp_t execute_instruction(mrte_pkg::req_t r);
        mrte_pkg::rsp_t res;
        logic [31:0]    rs_val;
        logic [31:0]    rt_val;
        logic [4:0]     rs;
        logic [4:0]     rt;
        logic [4:0]     rd;
        logic [4:0]     sa;
        logic [31:0]    sum;
        logic [63:0]    prod;
        logic [31:0]    abs_a;
        logic [31:0]    abs_b;
        logic [31:0]    quot;
        logic [31:0]    remd;
        bit             wr;
        bit             jmp;
        logic [31:0]    val;
        logic [31:0]    target;
        mrte_pkg::exc_t exc;

        rs = r.instruction_word[25:21];
        rt = r.instruction_word[20:16];
        rs_val = (rs == 5'd0) ? 32'd0 : gpr_mirror[rs];
        rt_val = (rt == 5'd0) ? 32'd0 : gpr_mirror[rt];
        rd = r.instruction_word[15:11];
        sa = r.instruction_word[10:6];
        wr = 0;
        jmp = 0;
        val = '0;
        target = '0;
        exc = mrte_pkg::EXC_NONE;
        case (r.operation)
            mrte_pkg::OP_AND:  begin wr = 1; val = rs_val & rt_val; end
            mrte_pkg::OP_ADDU: begin wr = 1; val = rs_val + rt_val; end
            mrte_pkg::OP_ADD:
            begin
                sum = rs_val + rt_val;
                if (((rs_val ^ sum) & (rt_val ^ sum)) >> 31) exc = mrte_pkg::EXC_OVERFLOW;
                else begin wr = 1; val = sum; end
            end
            mrte_pkg::OP_SUBU: begin wr = 1; val = rs_val - rt_val; end
            mrte_pkg::OP_SUB:
            begin
                sum = rs_val - rt_val;
                if (((rs_val ^ rt_val) & (rs_val ^ sum)) >> 31) exc = mrte_pkg::EXC_OVERFLOW;
                else begin wr = 1; val = sum; end
            end
            mrte_pkg::OP_NOR:  begin wr = 1; val = ~(rs_val | rt_val); end
            mrte_pkg::OP_OR:   begin wr = 1; val = rs_val | rt_val; end
            mrte_pkg::OP_XOR:  begin wr = 1; val = rs_val ^ rt_val; end
            mrte_pkg::OP_SLL:  begin wr = 1; val = rt_val << sa; end
            mrte_pkg::OP_SRL:  begin wr = 1; val = rt_val >> sa; end
            mrte_pkg::OP_SLLV: begin wr = 1; val = rt_val << rs_val[4:0]; end
            mrte_pkg::OP_SRLV: begin wr = 1; val = rt_val >> rs_val[4:0]; end
            mrte_pkg::OP_SRA:  begin wr = 1; val = arith_shift_right(rt_val, sa); end
            mrte_pkg::OP_SRAV: begin wr = 1; val = arith_shift_right(rt_val, rs_val[4:0]); end
            mrte_pkg::OP_SLT:
            begin
                wr = 1; val = ($signed(rs_val) < $signed(rt_val)) ? 32'd1 : 32'd0;
            end
            mrte_pkg::OP_SLTU: begin wr = 1; val = (rs_val < rt_val) ? 32'd1 : 32'd0; end
            mrte_pkg::OP_MFHI: begin wr = 1; val = hi_mirror; end
            mrte_pkg::OP_MTHI: hi_mirror = rs_val;
            mrte_pkg::OP_MFLO: begin wr = 1; val = lo_mirror; end
            mrte_pkg::OP_MTLO: lo_mirror = rs_val;
            mrte_pkg::OP_MULT:
            begin
                prod = $unsigned(64'($signed(rs_val)) * 64'($signed(rt_val)));
                {hi_mirror, lo_mirror} = prod;
            end
            mrte_pkg::OP_MULTU:
            begin
                prod = {32'd0, rs_val} * {32'd0, rt_val};
                {hi_mirror, lo_mirror} = prod;
            end
            mrte_pkg::OP_DIV:
            begin
                // Magnitude divide keeps the 0x80000000 / -1 case well defined.
                if (rt_val != 0)
                begin
                    abs_a = rs_val[31] ? -rs_val : rs_val;
                    abs_b = rt_val[31] ? -rt_val : rt_val;
                    quot = abs_a / abs_b;
                    remd = abs_a % abs_b;
                    lo_mirror = (rs_val[31] != rt_val[31]) ? -quot : quot;
                    hi_mirror = rs_val[31] ? -remd : remd;
                end
            end
            mrte_pkg::OP_DIVU:
            begin
                if (rt_val != 0)
                begin
                    lo_mirror = rs_val / rt_val;
                    hi_mirror = rs_val % rt_val;
                end
            end
            mrte_pkg::OP_JR:   begin jmp = 1; target = rs_val; end
            mrte_pkg::OP_JALR:
            begin
                jmp = 1; target = rs_val; wr = 1; val = r.current_pc + mrte_pkg::LINK_OFFSET;
            end
            mrte_pkg::OP_SYSCALL: exc = mrte_pkg::EXC_SYSCALL;
            mrte_pkg::OP_BREAK:   exc = mrte_pkg::EXC_BREAK;
            default: ;
        endcase
        if (wr && rd == 5'd0) wr = 0;
        if (wr) gpr_mirror[rd] = val;
        res.write_enable = wr;
        res.write_register = wr ? rd : 5'd0;
        res.write_value = wr ? val : 32'd0;
        res.jump_taken = jmp;
        res.jump_target = jmp ? target : 32'd0;
        res.exception_code = exc;
        res.exception_pc = (exc == mrte_pkg::EXC_NONE) ? 32'd0 :
                           (r.in_delay_slot ? r.current_pc - mrte_pkg::SLOT_OFFSET
                                            : r.current_pc);
        res.exception_in_delay_slot = (exc != mrte_pkg::EXC_NONE) && r.in_delay_slot;
        return res;
    endfunction

    function automatic logic [31:0] make_word(logic [4:0] rs, logic [4:0] rt,
                                              logic [4:0] rd, logic [4:0] sa);
        logic [31:0] w;
        w = $urandom;
        w[25:21] = rs;
        w[20:16] = rt;
        w[15:11] = rd;
        w[10:6] = sa;
        return w;
    endfunction

    // Sends one request, idling beforehand at the current sender rate.
    task automatic send_request(logic [4:0] op, logic [31:0] word,
                                logic [31:0] pc, logic slot);
        mrte_pkg::req_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        r.operation = op;
        r.instruction_word = word;
        r.current_pc = pc;
        r.in_delay_slot = slot;
        req_ch.valid = 1'b1;
        req_ch.payload = r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        scoreboard.note_request(execute_instruction(r));
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (scoreboard.pending_results.size() != 0) @(negedge clk);
    endtask

    // Builds random register contents from the link value of jalr (pc + 8).
    task automatic seed_registers();
        for (int i = 1; i < 32; i++)
            send_request(mrte_pkg::OP_JALR,
                         make_word(5'($urandom), 5'($urandom), 5'(i), 5'($urandom)),
                         $urandom, 1'($urandom_range(1)));
    endtask

    // Random request: register numbers are drawn over the full range, with extra divides.
    task automatic random_request();
        logic [4:0]  op;
        logic [4:0]  rd;
        logic [31:0] pc;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 4) op = 5'($urandom_range(31));
        else if (pick < 8) op = 5'($urandom_range(mrte_pkg::OP_DIVU, mrte_pkg::OP_DIV));
        else op = 5'($urandom_range(27));
        rd = 5'($urandom);
        pc = $urandom;
        if ($urandom_range(9) == 0) pc = $urandom_range(3);
        if ($urandom_range(9) == 0) rd = 5'd0;
        send_request(op, make_word(5'($urandom), 5'($urandom), rd, 5'($urandom)),
                     pc, 1'($urandom_range(1)));
    endtask

    // Receiver: accepts results with random idling and optional long hold-off.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            scoreboard.check_result(rsp_ch.payload);
    end

    initial
    begin
        scoreboard = new();
        for (int i = 0; i < 32; i++) gpr_mirror[i] = '0;
        hi_mirror = '0;
        lo_mirror = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: read-after-reset zeros, extremes and a selection of operations.
        send_request(mrte_pkg::OP_MFHI, make_word(5'd0, 5'd0, 5'd1, 5'd0), 32'd0, 1'b0);
        seed_registers();
        // Craft extreme values: 0x80000000 by shifting a one, -1 by nor of zeros.
        send_request(mrte_pkg::OP_NOR, make_word(5'd0, 5'd0, 5'd2, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_SRL, make_word(5'd0, 5'd2, 5'd3, 5'd31), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_SLL, make_word(5'd0, 5'd3, 5'd4, 5'd31), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_SRA, make_word(5'd0, 5'd4, 5'd5, 5'd31), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_SRL, make_word(5'd0, 5'd2, 5'd6, 5'd1), 32'd0, 1'b0);
        // Overflow of add and sub, and a write to register zero.
        send_request(mrte_pkg::OP_ADD, make_word(5'd6, 5'd6, 5'd7, 5'd0), 32'd4, 1'b0);
        send_request(mrte_pkg::OP_SUB, make_word(5'd4, 5'd3, 5'd7, 5'd0), 32'd0, 1'b1);
        send_request(mrte_pkg::OP_ADDU, make_word(5'd2, 5'd2, 5'd0, 5'd0), 32'd0, 1'b0);
        // Signed divide of the most negative value by -1, and divide by zero.
        send_request(mrte_pkg::OP_DIV, make_word(5'd4, 5'd2, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_DIVU, make_word(5'd4, 5'd0, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MFLO, make_word(5'd0, 5'd0, 5'd8, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MULT, make_word(5'd4, 5'd4, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MFHI, make_word(5'd0, 5'd0, 5'd9, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MULTU, make_word(5'd2, 5'd2, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MTHI, make_word(5'd2, 5'd0, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_MTLO, make_word(5'd4, 5'd0, 5'd0, 5'd0), 32'd0, 1'b0);
        // jalr reading and linking the same register.
        send_request(mrte_pkg::OP_JALR, make_word(5'd10, 5'd0, 5'd10, 5'd0),
                     32'hFFFF_FFFC, 1'b0);
        send_request(mrte_pkg::OP_JR, make_word(5'd2, 5'd0, 5'd0, 5'd0), 32'd0, 1'b0);
        send_request(mrte_pkg::OP_SYSCALL, make_word(5'd0, 5'd0, 5'd0, 5'd0), 32'd0, 1'b1);
        send_request(mrte_pkg::OP_BREAK, make_word(5'd0, 5'd0, 5'd0, 5'd0),
                     32'hFFFF_FFFF, 1'b0);
        send_request(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_for_drain();

        // Long receiver hold-off while requests keep coming, so the input stalls.
        fork
            begin
                recv_hold = 1;
                repeat (300) @(negedge clk);
                recv_hold = 0;
            end
            for (int i = 0; i < 30; i++) random_request();
        join
        wait_for_drain();

        // Random phases with alternating idling.
        send_idle_pct = 7;
        recv_idle_pct = 86;
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_request();
        // Sender pauses until every expected result has come back.
        wait_for_drain();
        send_idle_pct = 86;
        recv_idle_pct = 7;
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_request();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
